// ----- design/nmt_pkg.sv -----
// Shared types and codes for the node-to-MAC neighbor table.
package nmt_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] node_key;
    logic [47:0] mac_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] mac_out;
  } rsp_t;

  typedef struct packed {
    logic [15:0] node;
    logic [47:0] mac;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

// ----- design/nmt_mem.sv -----
// Entry store: one write port, one registered read port.
module nmt_mem import nmt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int IDX_W         = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/nmt_ctrl.sv -----
// Scan sequencer: walks the entry store, tracks valid bits, applies the operation.
module nmt_ctrl import nmt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int IDX_W         = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  req_t             req,
  output logic             busy,
  output logic             done,
  output rsp_t             result,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output entry_t           mem_wdata,
  output logic [IDX_W-1:0] mem_raddr,
  input  entry_t           mem_rdata
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t state, state_next;

  logic [TABLE_ENTRIES-1:0] valid;
  logic                     cmp_vld;
  req_t                     cur;
  logic [IDX_W-1:0]         scan_idx;
  logic [IDX_W-1:0]         cmp_idx;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  logic [47:0]              hit_mac;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;

  logic                     match;
  logic                     cmp_last;
  logic                     set_en;
  logic                     clr_en;
  rsp_t                     result_next;

  assign busy      = (state != S_IDLE);
  assign mem_raddr = scan_idx;
  assign match     = cmp_vld && valid[cmp_idx] && (mem_rdata.node == cur.node_key);
  assign cmp_last  = (cmp_idx == LAST_IDX);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmp_vld && (match || cmp_last)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // finish-cycle actions
  always_comb begin
    mem_we              = 1'b0;
    mem_waddr           = hit_idx;
    mem_wdata.node      = cur.node_key;
    mem_wdata.mac       = cur.mac_in;
    set_en              = 1'b0;
    clr_en              = 1'b0;
    result_next.status  = STAT_NOT_FOUND;
    result_next.mac_out = '0;
    if (state == S_FINISH) begin
      unique case (cur.operation)
        OP_ADD: begin
          if (hit) begin
            mem_we             = 1'b1;
            result_next.status = STAT_OK;
          end else if (free_found) begin
            mem_we             = 1'b1;
            mem_waddr          = free_idx;
            set_en             = 1'b1;
            result_next.status = STAT_OK;
          end else begin
            result_next.status = STAT_FULL;
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            clr_en             = 1'b1;
            result_next.status = STAT_OK;
          end
        end
        OP_FIND: begin
          if (hit) begin
            result_next.status  = STAT_OK;
            result_next.mac_out = hit_mac;
          end
        end
        default: begin
          result_next.status = STAT_NOT_FOUND;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      valid   <= '0;
      cmp_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= (state == S_SCAN) && (state_next == S_SCAN);
      done    <= (state == S_FINISH);
      if (set_en) begin
        valid[free_idx] <= 1'b1;
      end
      if (clr_en) begin
        valid[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cur        <= req;
      scan_idx   <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end
    if (state == S_SCAN) begin
      // hold the read address on the last entry so it never leaves the store
      if (scan_idx != LAST_IDX) begin
        scan_idx <= scan_idx + 1'b1;
      end
      cmp_idx <= scan_idx;
      if (match) begin
        hit     <= 1'b1;
        hit_idx <= cmp_idx;
        hit_mac <= mem_rdata.mac;
      end
      if (cmp_vld && !valid[cmp_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
    if (state == S_FINISH) begin
      result <= result_next;
    end
  end

endmodule

// ----- design/node_mac_neighbor_table_unit.sv -----
// Top level of the node-to-MAC neighbor table.
// Each transfer (start high while busy is low) runs one add, remove or find and
// yields exactly one result, shown on result for a single cycle with done high;
// the receiver cannot stall it, so capture it then. A first scan step issues
// the read of entry 0 from the entry store (one registered read port, one
// write port), then one compare follows per entry until a match or the last
// entry, then a finish step applies the operation and writes back, with the
// result registered out alongside done. busy is low again in the done cycle,
// so the next item can be accepted at the edge that ends it. Valid bits are
// flip-flops cleared by reset, so no clearing pass is needed.
module node_mac_neighbor_table_unit import nmt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t result
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  nmt_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  nmt_mem #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule
